FILE: rtl/core/ssid_pkg.sv
// Package for the sorted set insert/delete core.
// Holds the transfer structs, the cell control codes and the default capacity.
// No dependencies.
package ssid_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 6;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic [1:0] {
    OUTCOME_CHANGED   = 2'd0,
    OUTCOME_UNCHANGED = 2'd1,
    OUTCOME_FULL      = 2'd2
  } outcome_e;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_e;

  typedef struct packed {
    logic                       mode;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         count;
    logic signed [VALUE_W-1:0] element;
    logic                       is_empty;
    logic [1:0]                 outcome;
    logic                       last;
  } res_t;

  typedef struct packed {
    cell_op_e                   op;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic                       valid;
    logic signed [VALUE_W-1:0] value;
  } cell_t;

endpackage

FILE: rtl/core/ssid_cell.sv
// One cell of the sorted chain: a value register and a valid bit.
// Depends on ssid_pkg for the control and neighbor structs.
module ssid_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssid_pkg::cell_ctrl_t ctrl_i,
  input  ssid_pkg::cell_t    prev_i,
  input  logic               prev_lt_i,
  input  ssid_pkg::cell_t    next_i,
  input  ssid_pkg::cell_t    head_i,
  output ssid_pkg::cell_t    cell_o,
  output logic               lt_o,
  output logic               hit_o
);
  import ssid_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [VALUE_W-1:0] value_q, value_d;

  assign lt_o   = valid_q && (value_q < ctrl_i.value);
  assign hit_o  = valid_q && (value_q == ctrl_i.value);
  assign cell_o = '{valid: valid_q, value: value_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        valid_d = valid_q | prev_i.valid;
        if (!lt_o) begin
          value_d = prev_lt_i ? ctrl_i.value : prev_i.value;
        end
      end
      CELL_DELETE: begin
        if (!lt_o) begin
          valid_d = next_i.valid;
          value_d = next_i.value;
        end
      end
      CELL_ROTATE: begin
        value_d = next_i.valid ? next_i.value : head_i.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

FILE: rtl/core/sorted_set_insert_delete_core.sv
// Top level of the sorted set insert/delete core.
// Builds the chain of ssid_cell instances and the streaming sequencer.
// Depends on ssid_pkg and ssid_cell.
//
// Usage: an operation (insert or delete of one signed value) is transferred
// when start_i is high and busy_o is low. The update is applied to the chain
// of cells at that same edge. From the next cycle on, the block streams the
// whole set in ascending order, one result per cycle on res_o, each marked by
// res_strobe_o for exactly one cycle; last marks the final result. An empty
// set gives a single result with is_empty set. busy_o stays high until the
// final result has been shown, while the readout rotates the chain one cell
// per cycle. The receiver cannot stall; results are never held back.
// Reset clears the count, the valid bits of all cells and the sequencer;
// the first result appears in the cycle after the first transfer.
module sorted_set_insert_delete_core #(
  parameter int unsigned CAPACITY = ssid_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  ssid_pkg::req_t req_i,
  output logic           res_strobe_o,
  output ssid_pkg::res_t res_o
);
  import ssid_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [1:0]      outcome_q, outcome_d;

  cell_ctrl_t      ctrl;
  cell_t           cells [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] hit;

  logic accept, found, full, empty, last;

  assign accept = start_i && (state_q == ST_IDLE);
  assign found  = |hit;
  assign full   = (count_q == CW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign last   = empty || (idx_q == CW'(count_q - 1'b1));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t prev, next;
    logic  prev_lt;
    if (i == 0) begin : g_first
      assign prev    = '{valid: 1'b1, value: '0};
      assign prev_lt = 1'b1;
    end else begin : g_mid
      assign prev    = cells[i-1];
      assign prev_lt = lt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign next = '{valid: 1'b0, value: '0};
    end else begin : g_nxt
      assign next = cells[i+1];
    end
    ssid_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i    (ctrl),
      .prev_i    (prev),
      .prev_lt_i (prev_lt),
      .next_i    (next),
      .head_i    (cells[0]),
      .cell_o    (cells[i]),
      .lt_o      (lt[i]),
      .hit_o     (hit[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    outcome_d    = outcome_q;
    ctrl.op      = CELL_HOLD;
    ctrl.value   = req_i.value;
    busy_o       = 1'b1;
    res_strobe_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (accept) begin
          state_d = ST_STREAM;
          idx_d   = '0;
          if (req_i.mode == MODE_INSERT) begin
            if (found) begin
              outcome_d = OUTCOME_UNCHANGED;
            end else if (full) begin
              outcome_d = OUTCOME_FULL;
            end else begin
              outcome_d = OUTCOME_CHANGED;
              ctrl.op   = CELL_INSERT;
              count_d   = count_q + 1'b1;
            end
          end else begin
            if (found) begin
              outcome_d = OUTCOME_CHANGED;
              ctrl.op   = CELL_DELETE;
              count_d   = count_q - 1'b1;
            end else begin
              outcome_d = OUTCOME_UNCHANGED;
            end
          end
        end
      end
      ST_STREAM: begin
        res_strobe_o = 1'b1;
        if (!empty) begin
          ctrl.op = CELL_ROTATE;
        end
        if (last) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.count    = COUNT_W'(count_q);
    res_o.element  = empty ? '0 : cells[0].value;
    res_o.is_empty = empty;
    res_o.outcome  = outcome_q;
    res_o.last     = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      outcome_q <= OUTCOME_CHANGED;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      outcome_q <= outcome_d;
    end
  end

endmodule

FILE: sim/ssid_checker.sv
// Checker for the sorted set insert/delete core: watches the operation and result channels.
// Keeps its own copy of the set, predicts each readout and compares it field by field.
// Depends on ssid_pkg.
module ssid_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  ssid_pkg::req_t req_i,
  input  logic           res_strobe_i,
  input  ssid_pkg::res_t res_i,
  output int unsigned    pending_o,
  output int unsigned    mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ssid_pkg::*;

  localparam int unsigned SET_CAP = CAPACITY_DEF;

  logic signed [VALUE_W-1:0] set_vals [SET_CAP];
  int unsigned               set_size;
  res_t                      listing_q [$];
  int unsigned               mismatches = 0;

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic update_set_and_listing(input req_t req);
    int unsigned pos;
    int unsigned i;
    bit          found;
    outcome_e    code;
    res_t        r;
    pos = 0;
    while (pos < set_size && $signed(set_vals[pos]) < $signed(req.value)) pos++;
    found = (pos < set_size) && (set_vals[pos] == req.value);
    if (req.mode == MODE_INSERT) begin
      if (found) begin
        code = OUTCOME_UNCHANGED;
      end else if (set_size >= SET_CAP) begin
        code = OUTCOME_FULL;
      end else begin
        for (i = set_size; i > pos; i--) set_vals[i] = set_vals[i-1];
        set_vals[pos] = req.value;
        set_size++;
        code = OUTCOME_CHANGED;
      end
    end else begin
      if (!found) begin
        code = OUTCOME_UNCHANGED;
      end else begin
        for (i = pos; i + 1 < set_size; i++) set_vals[i] = set_vals[i+1];
        set_size--;
        code = OUTCOME_CHANGED;
      end
    end
    if (set_size == 0) begin
      r.count    = '0;
      r.element  = '0;
      r.is_empty = 1'b1;
      r.outcome  = code;
      r.last     = 1'b1;
      listing_q.push_back(r);
    end else begin
      for (i = 0; i < set_size; i++) begin
        r.count    = COUNT_W'(set_size);
        r.element  = set_vals[i];
        r.is_empty = 1'b0;
        r.outcome  = code;
        r.last     = (i + 1 == set_size);
        listing_q.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      set_size = 0;
      listing_q.delete();
      pending_o <= 0;
    end else begin
      if (res_strobe_i) begin
        if (listing_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, actual element %0d count %0d",
                   $time, res_i.element, res_i.count);
        end else begin
          want = listing_q.pop_front();
          compare_field("count", longint'(want.count), longint'(res_i.count));
          compare_field("element", longint'($signed(want.element)),
                        longint'($signed(res_i.element)));
          compare_field("is_empty", longint'(want.is_empty), longint'(res_i.is_empty));
          compare_field("outcome", longint'(want.outcome), longint'(res_i.outcome));
          compare_field("last", longint'(want.last), longint'(res_i.last));
        end
      end
      if (start_i && !busy_i) update_set_and_listing(req_i);
      pending_o <= listing_q.size();
    end
    mismatches_o <= mismatches;
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the sorted set insert/delete core: clock, reset, operation stimulus, verdict.
// Prediction and comparison live in ssid_checker, instantiated beside the block.
// Depends on ssid_pkg, ssid_checker and sorted_set_insert_delete_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssid_pkg::*;

  localparam int unsigned POOL_N         = 48;
  localparam int unsigned ROUND_LEN      = 50;
  localparam int unsigned RANDOM_ITEMS   = 300;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  req_t        req_i = '0;
  logic        busy_o;
  logic        res_strobe_o;
  res_t        res_o;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  logic signed [VALUE_W-1:0] pool [POOL_N];

  sorted_set_insert_delete_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  ssid_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .res_strobe_i(res_strobe_o),
    .res_i       (res_o),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_strobe_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_op(input mode_e m, input logic signed [VALUE_W-1:0] v);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= '{mode: m, value: v};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned ins_pct;
    mode_e       m;
    logic signed [VALUE_W-1:0] v;

    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = VAL_MIN;
    pool[1] = VAL_MAX;
    pool[2] = '0;
    pool[3] = -1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(MODE_DELETE, 32'sd5);
    send_op(MODE_INSERT, 32'sd0);
    send_op(MODE_INSERT, VAL_MIN);
    send_op(MODE_INSERT, VAL_MAX);
    send_op(MODE_INSERT, -32'sd1);
    send_op(MODE_INSERT, 32'sd1);
    send_op(MODE_INSERT, 32'sd0);
    send_op(MODE_INSERT, 32'sh5555_5555);
    send_op(MODE_INSERT, 32'shaaaa_aaaa);
    send_op(MODE_DELETE, 32'sd12345);
    send_op(MODE_DELETE, VAL_MIN);
    send_op(MODE_DELETE, VAL_MAX);
    send_op(MODE_DELETE, 32'sd0);
    send_op(MODE_DELETE, 32'sh5555_5555);
    send_op(MODE_DELETE, 32'shaaaa_aaaa);
    send_op(MODE_DELETE, -32'sd1);
    send_op(MODE_DELETE, 32'sd1);
    send_op(MODE_DELETE, 32'sd1);

    // Rounds alternate between filling the set, mixed traffic and draining it.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 3)
        0: begin
          ins_pct = 90;
        end
        1: begin
          ins_pct = 50;
        end
        default: begin
          ins_pct = 15;
        end
      endcase
      quiet = ($urandom_range(3, 0) == 0);
      repeat (ROUND_LEN) begin
        m = ($urandom_range(99, 0) < ins_pct) ? MODE_INSERT : MODE_DELETE;
        v = ($urandom_range(4, 0) == 0) ? $urandom : pool[$urandom_range(POOL_N - 1, 0)];
        send_op(m, v);
      end
      sent += ROUND_LEN;
      phase++;
    end
    start_i <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sorted_set_insert_delete_core.f
rtl/core/ssid_pkg.sv
rtl/core/ssid_cell.sv
rtl/core/sorted_set_insert_delete_core.sv
sim/ssid_checker.sv
sim/tb.sv
